FILE: src/mcdt_pkg.sv
`default_nettype none

package mcdt_pkg;

  // Command codes as they arrive on the input beat; code 7 has no meaning.
  typedef enum logic [2:0] {
    MODE_TICK         = 3'd0,
    MODE_ADD_ONESHOT  = 3'd1,
    MODE_ADD_PERIODIC = 3'd2,
    MODE_CANCEL       = 3'd3,
    MODE_RELEASE      = 3'd4,
    MODE_STOP         = 3'd5,
    MODE_RESUME       = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_INVALID   = 3'd1,
    STS_FULL      = 3'd2,
    STS_CANCELLED = 3'd3,
    STS_BUSY      = 3'd4,
    STS_STOPPED   = 3'd5,
    STS_NOT_DONE  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    SS_NONE     = 3'd0,
    SS_RUN      = 3'd1,
    SS_DONE     = 3'd2,
    SS_CANCEL   = 3'd3,
    SS_STOP     = 3'd4,
    SS_PERIODIC = 3'd5
  } slot_state_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_CANCEL,
    OP_RELEASE,
    OP_STOP,
    OP_RESUME,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SLOT,
    B_TICK,
    B_FIND
  } bstate_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] period;
    logic [5:0]  slot;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  assigned_slot;
    logic [15:0] fire_mask;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic        periodic;
    logic [15:0] period;
    logic [5:0]  slot;
  } job_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

FILE: src/mcdt_front.sv
`default_nettype none

module mcdt_front import mcdt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  req_t req,
  output job_t job
);

  logic slot_ok;

  assign slot_ok = 7'(req.slot) < 7'(SLOTS);

  always_comb begin
    job.op       = OP_REJECT;
    job.periodic = 1'b0;
    job.period   = req.period;
    job.slot     = req.slot;
    unique case (req.mode)
      MODE_TICK: job.op = OP_TICK;
      MODE_ADD_ONESHOT, MODE_ADD_PERIODIC: begin
        // zero period is refused before any table search
        job.op       = (req.period == 16'd0) ? OP_REJECT : OP_ADD;
        job.periodic = (req.mode == MODE_ADD_PERIODIC);
      end
      MODE_CANCEL:  job.op = slot_ok ? OP_CANCEL  : OP_REJECT;
      MODE_RELEASE: job.op = slot_ok ? OP_RELEASE : OP_REJECT;
      MODE_STOP:    job.op = slot_ok ? OP_STOP    : OP_REJECT;
      MODE_RESUME:  job.op = slot_ok ? OP_RESUME  : OP_REJECT;
      default:      job.op = OP_REJECT;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/mcdt_queue.sv
`default_nettype none

module mcdt_queue import mcdt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t data
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: src/mcdt_back.sv
`default_nettype none

module mcdt_back import mcdt_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_data,
  output logic q_pop,
  output logic res_valid,
  input  logic res_stall,
  output rsp_t res
);

  localparam int          SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int          CW      = COUNT_BITS;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  typedef struct packed {
    slot_state_t     st;
    logic            periodic;
    logic [CW-1:0]   rem;
    logic [CW-1:0]   rel;
  } entry_t;

  entry_t              mem [SLOTS];
  entry_t              rdata;
  entry_t              wdata;
  logic                re;
  logic                we;
  logic [SLOT_W-1:0]   raddr;
  logic [SLOT_W-1:0]   waddr;

  logic [SLOTS-1:0]    used;
  logic                used_set;
  logic                used_clr;
  logic [SLOT_W-1:0]   used_idx;

  bstate_t             state;
  bstate_t             state_next;
  job_t                cur;
  logic [SLOT_W-1:0]   idx;
  logic [SLOT_W-1:0]   idx_next;
  logic [5:0]          idx6;
  logic [15:0]         fire;
  logic [15:0]         fire_next;
  logic                res_load;
  rsp_t                res_next;

  logic                out_free;
  logic                start;
  logic [SLOT_W-1:0]   q_slot;
  logic [SLOT_W-1:0]   cur_slot;
  logic                q_slot_used;
  logic                idx_last;
  logic                idx_used;
  logic                tick_active;
  logic                tick_fire;
  logic [CW-1:0]       rem_dec;
  logic [31:0]         per32;
  logic [CW-1:0]       per_sat;

  // Slot payload store, one read and one write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign out_free    = !res_valid || !res_stall;
  assign start       = (state == B_IDLE) && q_valid && out_free;
  assign q_slot      = q_data.slot[SLOT_W-1:0];
  assign cur_slot    = cur.slot[SLOT_W-1:0];
  assign q_slot_used = used[q_slot];
  assign idx_last    = idx == LAST;
  assign idx_used    = used[idx];
  assign idx6        = 6'(idx);
  assign tick_active = idx_used && (rdata.st == SS_RUN || rdata.st == SS_PERIODIC);
  assign rem_dec     = rdata.rem - CW'(1);
  assign tick_fire   = tick_active && (rem_dec == '0);
  assign per32       = 32'(cur.period);
  assign per_sat     = CW'((per32 > CNT_MAX) ? CNT_MAX : per32);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (start) begin
          unique case (q_data.op)
            OP_TICK: state_next = B_TICK;
            OP_ADD:  state_next = B_FIND;
            OP_CANCEL, OP_RELEASE, OP_STOP, OP_RESUME:
              state_next = q_slot_used ? B_SLOT : B_IDLE;
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_SLOT: state_next = B_IDLE;
      B_TICK: state_next = idx_last ? B_IDLE : B_TICK;
      B_FIND: state_next = (!idx_used || idx_last) ? B_IDLE : B_FIND;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = idx;
    wdata     = rdata;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    used_idx  = idx;
    idx_next  = idx;
    fire_next = fire;
    res_load  = 1'b0;
    res_next.status        = STS_OK;
    res_next.assigned_slot = 4'd0;
    res_next.fire_mask     = 16'd0;
    unique case (state)
      B_IDLE: begin
        if (start) begin
          q_pop     = 1'b1;
          idx_next  = '0;
          fire_next = 16'd0;
          unique case (q_data.op)
            OP_TICK: begin
              re    = 1'b1;
              raddr = '0;
            end
            OP_ADD: ;
            OP_CANCEL, OP_RELEASE, OP_STOP, OP_RESUME: begin
              if (q_slot_used) begin
                re    = 1'b1;
                raddr = q_slot;
              end else begin
                res_load        = 1'b1;
                res_next.status = STS_INVALID;
              end
            end
            default: begin
              res_load        = 1'b1;
              res_next.status = STS_INVALID;
            end
          endcase
        end
      end
      B_SLOT: begin
        waddr    = cur_slot;
        used_idx = cur_slot;
        res_load = 1'b1;
        unique case (cur.op)
          OP_CANCEL: begin
            if (rdata.st == SS_CANCEL) begin
              res_next.status = STS_CANCELLED;
            end else if (rdata.st == SS_DONE) begin
              res_next.status = STS_BUSY;
            end else begin
              we       = 1'b1;
              wdata.st = SS_CANCEL;
            end
          end
          OP_RELEASE: begin
            if (rdata.st == SS_PERIODIC) begin
              res_next.status = STS_BUSY;
            end else if (rdata.st == SS_DONE || rdata.st == SS_CANCEL) begin
              used_clr = 1'b1;
            end else begin
              res_next.status = STS_NOT_DONE;
            end
          end
          OP_STOP: begin
            if (rdata.st == SS_DONE || rdata.st == SS_CANCEL) begin
              res_next.status = STS_BUSY;
            end else if (rdata.st == SS_STOP) begin
              res_next.status = STS_STOPPED;
            end else begin
              we       = 1'b1;
              wdata.st = SS_STOP;
            end
          end
          OP_RESUME: begin
            if (rdata.st != SS_STOP) begin
              res_next.status = STS_INVALID;
            end else begin
              we       = 1'b1;
              wdata.st = rdata.periodic ? SS_PERIODIC : SS_RUN;
            end
          end
          default: res_next.status = STS_INVALID;
        endcase
      end
      B_TICK: begin
        if (tick_active) begin
          we        = 1'b1;
          wdata.rem = rem_dec;
          if (tick_fire) begin
            if (rdata.st == SS_RUN) begin
              wdata.st = SS_DONE;
            end else begin
              wdata.rem = rdata.rel;
            end
            if (idx6 < 6'd16) begin
              fire_next[idx6[3:0]] = 1'b1;
            end
          end
        end
        if (idx_last) begin
          res_load           = 1'b1;
          res_next.fire_mask = fire_next;
        end else begin
          // fetch the next slot while this one is written back
          re       = 1'b1;
          raddr    = idx + SLOT_W'(1);
          idx_next = idx + SLOT_W'(1);
        end
      end
      B_FIND: begin
        if (!idx_used) begin
          we             = 1'b1;
          wdata.st       = cur.periodic ? SS_PERIODIC : SS_RUN;
          wdata.periodic = cur.periodic;
          wdata.rem      = per_sat;
          wdata.rel      = per_sat;
          used_set       = 1'b1;
          res_load       = 1'b1;
          res_next.assigned_slot = idx6[3:0];
        end else if (idx_last) begin
          res_load        = 1'b1;
          res_next.status = STS_FULL;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    idx  <= idx_next;
    fire <= fire_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (used_set) begin
        used[used_idx] <= 1'b1;
      end
      if (used_clr) begin
        used[used_idx] <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/multi_slot_countdown_timer_table.sv
// Order: a beat is written into the queue; from its head, a refused command or an
// unused slot is answered into the result register, cancel/release/stop/resume
// read the slot first, add walks the table up to a free slot and tick walks all
// of it (walk one slot per cycle). The back end takes one command at a time.
// Reset: synchronous, active high; empties the queue, marks every slot free and
// drops any pending result. No clearing pass is needed.
`default_nettype none

module multi_slot_countdown_timer_table import mcdt_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  req_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output rsp_t res
);

  job_t front_job;
  job_t q_data;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  // Hold the command side off only when the queue has no room; the back end
  // may be busy walking slots or waiting on a stalled result meanwhile.
  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full;

  // Front: decode the mode, refuse zero periods, unknown codes and slots out
  // of range, so the back end answers refused work without reading the table.
  mcdt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .req (cmd),
    .job (front_job)
  );

  // Short queue that lets the front keep taking beats while the back works.
  mcdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // Back: own the slot table, advance counters on tick, search for a free
  // slot on add, and drive the registered result beat.
  mcdt_back #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: src/mcdt_checker.sv
`default_nettype none

module mcdt_checker import mcdt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic res_valid,
  input logic res_stall,
  input rsp_t res
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending;

  assign in_acc  = cmd_valid && !cmd_stall;
  assign out_acc = res_valid && !res_stall;

  // Count commands taken but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else begin
      pending <= pending + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_res_owed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 4'd0)
    else $error("result beat with no command outstanding");

  a_fire_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.fire_mask) >> SLOTS) == 32'd0)
    else $error("fire mask names a slot that does not exist");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.fire_mask != 16'd0 |-> res.status == STS_OK && res.assigned_slot == 4'd0)
    else $error("tick result carries a status or slot");

endmodule

bind multi_slot_countdown_timer_table mcdt_checker #(.SLOTS(SLOTS)) u_mcdt_checker (.*);

`default_nettype wire

FILE: test/timer_table_checker.sv
`timescale 1ns / 100ps

module timer_table_checker import mcdt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_stall,
  input  req_t cmd,
  input  logic res_valid,
  input  logic res_stall,
  input  rsp_t res,
  output int   fail_count,
  output int   pending
);

  // Shadow copy of the slot table.
  logic        used       [SLOTS];
  slot_state_t state_of   [SLOTS];
  logic        periodic   [SLOTS];
  logic [15:0] ticks_left [SLOTS];
  logic [15:0] reload     [SLOTS];

  rsp_t expected_replies[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void clear_slot(input int k);
    used[k]       = 1'b0;
    state_of[k]   = SS_NONE;
    periodic[k]   = 1'b0;
    ticks_left[k] = '0;
    reload[k]     = '0;
  endfunction

  // Apply one command to the shadow table and return the reply it must give.
  function automatic rsp_t apply_command(input req_t c);
    rsp_t r;
    int   k;
    int   i;
    int   free_idx;
    logic known;
    r        = '0;
    r.status = STS_OK;
    k        = int'(c.slot) % SLOTS;
    known    = (int'(c.slot) < SLOTS) && used[k];
    case (c.mode)
      MODE_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (used[i] && (state_of[i] == SS_RUN || state_of[i] == SS_PERIODIC)) begin
            ticks_left[i] = ticks_left[i] - 16'd1;
            if (ticks_left[i] == '0) begin
              if (i < 16) r.fire_mask[i] = 1'b1;
              if (state_of[i] == SS_RUN) state_of[i] = SS_DONE;
              else ticks_left[i] = reload[i];
            end
          end
        end
      end
      MODE_ADD_ONESHOT, MODE_ADD_PERIODIC: begin
        free_idx = -1;
        for (i = SLOTS - 1; i >= 0; i--)
          if (!used[i]) free_idx = i;
        if (c.period == '0) begin
          r.status = STS_INVALID;
        end else if (free_idx < 0) begin
          r.status = STS_FULL;
        end else begin
          used[free_idx]       = 1'b1;
          periodic[free_idx]   = (c.mode == MODE_ADD_PERIODIC);
          state_of[free_idx]   = (c.mode == MODE_ADD_PERIODIC) ? SS_PERIODIC : SS_RUN;
          ticks_left[free_idx] = c.period;
          reload[free_idx]     = c.period;
          r.assigned_slot      = 4'(free_idx);
        end
      end
      MODE_CANCEL: begin
        if (!known) r.status = STS_INVALID;
        else if (state_of[k] == SS_CANCEL) r.status = STS_CANCELLED;
        else if (state_of[k] == SS_DONE) r.status = STS_BUSY;
        else state_of[k] = SS_CANCEL;
      end
      MODE_RELEASE: begin
        if (!known) r.status = STS_INVALID;
        else if (state_of[k] == SS_PERIODIC) r.status = STS_BUSY;
        else if (state_of[k] == SS_DONE || state_of[k] == SS_CANCEL) clear_slot(k);
        else r.status = STS_NOT_DONE;
      end
      MODE_STOP: begin
        if (!known) r.status = STS_INVALID;
        else if (state_of[k] == SS_DONE || state_of[k] == SS_CANCEL) r.status = STS_BUSY;
        else if (state_of[k] == SS_STOP) r.status = STS_STOPPED;
        else state_of[k] = SS_STOP;
      end
      MODE_RESUME: begin
        if (!known || state_of[k] != SS_STOP) r.status = STS_INVALID;
        else state_of[k] = periodic[k] ? SS_PERIODIC : SS_RUN;
      end
      default: r.status = STS_INVALID;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      expected_replies.delete();
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
    end else begin
      // Results come after their command has passed the queue and the result register, so check first.
      if (res_valid && !res_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d slot %0d mask %h",
                   $time, res.status, res.assigned_slot, res.fire_mask);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (res.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, res.status);
            fail_count++;
          end
          if (res.assigned_slot !== want.assigned_slot) begin
            $display("%0t: assigned_slot expected %0d actual %0d",
                     $time, want.assigned_slot, res.assigned_slot);
            fail_count++;
          end
          if (res.fire_mask !== want.fire_mask) begin
            $display("%0t: fire_mask expected %h actual %h",
                     $time, want.fire_mask, res.fire_mask);
            fail_count++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) expected_replies.push_back(apply_command(cmd));
    end
    pending <= expected_replies.size();
  end

endmodule

FILE: test/tb_multi_slot_countdown_timer_table.sv
`timescale 1ns / 100ps

module tb_multi_slot_countdown_timer_table;
  import mcdt_pkg::*;

  localparam int         SLOTS          = 16;
  localparam int         TOTAL_ITEMS    = 1050;
  localparam int         WATCHDOG_LIMIT = 4000;
  // Add and tick can walk every slot, so allow a full walk plus margin at the end.
  localparam int         TAIL_CYCLES    = SLOTS + 8;
  localparam logic [2:0] MODE_UNUSED    = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  req_t cmd;
  logic res_valid;
  logic res_stall;
  rsp_t res;

  int fail_count;
  int pending;
  int beats_sent;
  int stall_run;
  bit calm;  // set: neither side idles

  multi_slot_countdown_timer_table #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (16)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  timer_table_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none, often a few cycles, now and then a long pause.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver back-pressure: hold each stall level for a random run of cycles.
  always @(posedge clk) begin
    if (rst || calm) begin
      res_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < 40);
      stall_run <= idle_length();
    end
  end

  function automatic req_t make_cmd(input logic [2:0] m, input logic [15:0] p,
                                    input logic [5:0] s);
    req_t c;
    c.mode   = m;
    c.period = p;
    c.slot   = s;
    return c;
  endfunction

  // Mostly short periods so timers fire often; sometimes wide or zero periods
  // and slots beyond the table.
  function automatic req_t random_command();
    int          roll;
    logic [15:0] p;
    logic [5:0]  s;
    logic [2:0]  m;
    roll = $urandom_range(0, 99);
    if (roll < 70) p = 16'($urandom_range(1, 4));
    else if (roll < 85) p = 16'($urandom_range(5, 40));
    else if (roll < 95) p = 16'($urandom);
    else p = '0;
    s = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, SLOTS - 1)) : 6'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 30) m = MODE_TICK;
    else if (roll < 40) m = MODE_ADD_ONESHOT;
    else if (roll < 50) m = MODE_ADD_PERIODIC;
    else if (roll < 62) m = MODE_CANCEL;
    else if (roll < 75) m = MODE_RELEASE;
    else if (roll < 86) m = MODE_STOP;
    else if (roll < 98) m = MODE_RESUME;
    else m = MODE_UNUSED;
    return make_cmd(m, p, s);
  endfunction

  // Present one beat and return at the edge that takes it, valid still high.
  // The caller drives the next beat or drops valid at that same edge.
  task automatic send_beat(input req_t c);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and wait until every outstanding reply has come back.
  task automatic hold_until_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int         roll;
    bit         drained;
    logic [2:0] sweep_mode;
    clk        = 1'b0;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    res_stall  = 1'b0;
    calm       = 1'b0;
    beats_sent = 0;
    drained    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, zero periods, extreme periods, commands against
    // done, running, stopped, cancelled and free slots, bad slots and the unused code.
    send_beat(make_cmd(MODE_TICK, '0, '0));
    send_beat(make_cmd(MODE_ADD_ONESHOT, '0, '0));
    send_beat(make_cmd(MODE_ADD_PERIODIC, '0, '0));
    send_beat(make_cmd(MODE_ADD_ONESHOT, 16'd1, '0));          // slot 0
    send_beat(make_cmd(MODE_ADD_PERIODIC, 16'd2, '0));         // slot 1
    send_beat(make_cmd(MODE_ADD_ONESHOT, 16'hFFFF, '0));       // slot 2
    send_beat(make_cmd(MODE_TICK, '0, '0));                    // slot 0 fires, done
    send_beat(make_cmd(MODE_TICK, '0, '0));                    // slot 1 fires, reloads
    send_beat(make_cmd(MODE_CANCEL, '0, 6'd0));                // done: busy
    send_beat(make_cmd(MODE_STOP, '0, 6'd0));                  // done: busy
    send_beat(make_cmd(MODE_RELEASE, '0, 6'd1));               // running periodic: busy
    send_beat(make_cmd(MODE_STOP, '0, 6'd1));
    send_beat(make_cmd(MODE_STOP, '0, 6'd1));                  // already stopped
    send_beat(make_cmd(MODE_RELEASE, '0, 6'd1));               // stopped: not finished
    send_beat(make_cmd(MODE_RESUME, '0, 6'd1));                // back to periodic
    send_beat(make_cmd(MODE_RESUME, '0, 6'd1));                // not stopped: invalid
    send_beat(make_cmd(MODE_CANCEL, '0, 6'd2));
    send_beat(make_cmd(MODE_CANCEL, '0, 6'd2));                // already cancelled
    send_beat(make_cmd(MODE_STOP, '0, 6'd2));                  // cancelled: busy
    send_beat(make_cmd(MODE_RELEASE, '0, 6'd2));               // frees slot 2
    send_beat(make_cmd(MODE_RELEASE, '0, 6'd0));               // frees slot 0
    send_beat(make_cmd(MODE_CANCEL, '0, 6'd63));               // beyond the table
    send_beat(make_cmd(MODE_RESUME, '0, 6'd16));
    send_beat(make_cmd(MODE_STOP, '0, 6'd5));                  // free slot
    send_beat(make_cmd(MODE_UNUSED, 16'hFFFF, 6'd63));
    send_beat(make_cmd(MODE_ADD_ONESHOT, 16'd3, '0));          // slot 0 again
    send_beat(make_cmd(MODE_RELEASE, '0, 6'd0));               // running: not finished
    send_beat(make_cmd(MODE_STOP, '0, 6'd0));
    send_beat(make_cmd(MODE_RESUME, '0, 6'd0));                // back to one-shot

    // Random: mostly single commands, with episodes that fill the table past
    // full and that sweep one command across every slot.
    while (beats_sent < TOTAL_ITEMS) begin
      calm <= (beats_sent >= 500 && beats_sent < 600);
      if (!drained && beats_sent >= 700) begin
        hold_until_drained();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        repeat (SLOTS + 2)
          send_beat(make_cmd($urandom_range(0, 1) ? MODE_ADD_PERIODIC : MODE_ADD_ONESHOT,
                             16'($urandom_range(1, 6)), 6'($urandom)));
      end else if (roll < 8) begin
        case ($urandom_range(0, 3))
          0:       sweep_mode = MODE_CANCEL;
          1:       sweep_mode = MODE_RELEASE;
          2:       sweep_mode = MODE_STOP;
          default: sweep_mode = MODE_RESUME;
        endcase
        for (int i = 0; i < SLOTS; i++)
          send_beat(make_cmd(sweep_mode, 16'($urandom), 6'(i)));
      end else begin
        send_beat(random_command());
      end
    end

    // Drain, let any stray beat show up, then give the verdict.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
